// ===== design/atli_pkg.sv =====
// Shared types and constants for the angle table linear interpolator.
package atli_pkg;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ABOVE     = 3'd1;
    localparam logic [2:0] ST_FIRST     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ZERO_SPAN = 3'd4;

    localparam logic [15:0] VALUE_ONE       = 16'd32768;
    localparam logic [15:0] MAX_ANGLE_RESET = 16'd25736;
    localparam logic [3:0]  DIV_LAST_STEP   = 4'd15;

    typedef enum logic [2:0] {
        RS_ZERO,
        RS_RDVAL,
        RS_V0,
        RS_V1,
        RS_INTERP
    } t_res_sel;

    typedef struct packed {
        logic       latch;
        logic       ld_init;
        logic       q_init;
        logic       rd_ld;
        logic       rd_q;
        logic       ld_shift;
        logic       ld_put;
        logic       clr;
        logic       q_next;
        logic       cap_hi;
        logic       div_init;
        logic       div_step;
        logic       mul;
        logic       fin;
        t_res_sel   fin_sel;
        logic [2:0] fin_st;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic k_zero;
        logic ld_gt;
        logic q_end;
        logic q_hit;
        logic i_zero;
        logic q_eq;
        logic span_zero;
        logic div_last;
    } t_dp_stat;

endpackage

// ===== design/angle_table_linear_interpolator.sv =====
// Top level of the angle table linear interpolator: controller, datapath and checks.
// A full-table load, a clear or an unused action strobes its word in the cycle after start;
// a load shifts each larger entry up, then writes; a query walks the entries and answers at
// once past every entry, at the first, on a hit or zero span, else divides and blends first.
// One word is handled at a time, paced by the table walk and the divider; results never stall.
// Reset (synchronous, active low) empties the table and restores max_angle to pi/2.
module angle_table_linear_interpolator
    import atli_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_entry_angle,
    input  logic [15:0] i_entry_value,
    input  logic [15:0] i_query_angle,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_done,
    output logic [15:0] o_result_value,
    output logic [2:0]  o_status
);

    // The controller only ever sees the status flags that the datapath raises, and the
    // datapath only acts on the command word; neither reaches into the other.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_start;

    // A new word is taken only while the sequencer is idle.
    assign w_start = start & ~busy;

    atli_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_action (i_action),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // The datapath holds the sorted table in two memories addressed together, the entry
    // count, the clamp register, the search bounds, the divider and the blending multiplier.
    atli_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_entry_angle  (i_entry_angle),
        .i_entry_value  (i_entry_value),
        .i_query_angle  (i_query_angle),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    // Every accepted word either keeps the block busy or has already produced its result.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted word neither in progress nor answered");

    // A result is only issued once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    // A query above every entry answers zero.
    a_above_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_ABOVE) |-> (o_result_value == 16'd0))
        else $error("non-zero result for a query above the table");

    // Results never exceed one in Q1.15.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result_value <= VALUE_ONE))
        else $error("result above one");

endmodule

// ===== design/atli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module atli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/atli_ctrl.sv =====
// Controller state machine that sequences loads, searches and the interpolation.
module atli_ctrl
    import atli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_action,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_CHK,
        S_LD_CMP,
        S_Q_CHK,
        S_Q_CMP,
        S_Q_EVAL,
        S_DIV,
        S_MUL,
        S_FIN
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd n_cmd;
    logic    r_busy;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        n_cmd.fin_sel = RS_ZERO;
        n_cmd.fin_st  = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd.latch = 1'b1;
                    case (i_action)
                        ACT_LOAD: begin
                            if (i_stat.full) begin
                                n_cmd.fin    = 1'b1;
                                n_cmd.fin_st = ST_FULL;
                            end else begin
                                n_cmd.ld_init = 1'b1;
                                n_state       = S_LD_CHK;
                            end
                        end
                        ACT_QUERY: begin
                            n_cmd.q_init = 1'b1;
                            n_state      = S_Q_CHK;
                        end
                        ACT_CLEAR: begin
                            n_cmd.clr = 1'b1;
                            n_cmd.fin = 1'b1;
                        end
                        default: begin
                            n_cmd.fin = 1'b1;
                        end
                    endcase
                end
            end
            S_LD_CHK: begin
                if (i_stat.k_zero) begin
                    n_cmd.ld_put = 1'b1;
                    n_cmd.fin    = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_cmd.rd_ld = 1'b1;
                    n_state     = S_LD_CMP;
                end
            end
            S_LD_CMP: begin
                if (i_stat.ld_gt) begin
                    n_cmd.ld_shift = 1'b1;
                    n_state        = S_LD_CHK;
                end else begin
                    n_cmd.ld_put = 1'b1;
                    n_cmd.fin    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_Q_CHK: begin
                if (i_stat.q_end) begin
                    n_cmd.fin    = 1'b1;
                    n_cmd.fin_st = ST_ABOVE;
                    n_state      = S_IDLE;
                end else begin
                    n_cmd.rd_q = 1'b1;
                    n_state    = S_Q_CMP;
                end
            end
            S_Q_CMP: begin
                if (i_stat.q_hit) begin
                    if (i_stat.i_zero) begin
                        n_cmd.fin     = 1'b1;
                        n_cmd.fin_sel = RS_RDVAL;
                        n_cmd.fin_st  = ST_FIRST;
                        n_state       = S_IDLE;
                    end else begin
                        n_cmd.cap_hi = 1'b1;
                        n_state      = S_Q_EVAL;
                    end
                end else begin
                    n_cmd.q_next = 1'b1;
                    n_state      = S_Q_CHK;
                end
            end
            S_Q_EVAL: begin
                if (i_stat.q_eq) begin
                    n_cmd.fin     = 1'b1;
                    n_cmd.fin_sel = RS_V1;
                    n_state       = S_IDLE;
                end else if (i_stat.span_zero) begin
                    n_cmd.fin     = 1'b1;
                    n_cmd.fin_sel = RS_V0;
                    n_cmd.fin_st  = ST_ZERO_SPAN;
                    n_state       = S_IDLE;
                end else begin
                    n_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                n_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                n_cmd.fin     = 1'b1;
                n_cmd.fin_sel = RS_INTERP;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = n_cmd;
    assign o_busy = r_busy;

endmodule

// ===== design/atli_dp.sv =====
// Datapath: table memories, search and insert registers, divider and blend.
module atli_dp
    import atli_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic [15:0] i_entry_angle,
    input  logic [15:0] i_entry_value,
    input  logic [15:0] i_query_angle,
    output logic        o_done,
    output logic [15:0] o_result_value,
    output logic [2:0]  o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [15:0] r_max;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_i;
    logic [15:0] r_ang;
    logic [15:0] r_val;
    logic [15:0] r_q;
    logic [15:0] r_a0;
    logic [15:0] r_v0;
    logic [15:0] r_a1;
    logic [15:0] r_v1;
    logic [15:0] r_rem;
    logic [15:0] r_span;
    logic [15:0] r_quo;
    logic [3:0]  r_dcnt;
    logic signed [33:0] r_prod;
    logic        r_done;
    logic [15:0] r_result;
    logic [2:0]  r_status;

    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [CW-1:0] w_k_dec;
    logic          w_we;
    logic          w_re;
    logic [15:0]   w_wang;
    logic [15:0]   w_wval;
    logic [15:0]   w_rang;
    logic [15:0]   w_rval;
    logic [16:0]   w_trial;
    logic signed [16:0] w_diff;
    logic signed [16:0] w_frac;
    logic signed [34:0] w_sum;
    logic [15:0]   w_interp;
    logic [15:0]   w_res;

    assign w_k_dec = r_k - CW'(1);
    assign w_raddr = i_cmd.rd_ld ? w_k_dec[AW-1:0] : r_i[AW-1:0];
    assign w_re    = i_cmd.rd_ld | i_cmd.rd_q;
    assign w_waddr = r_k[AW-1:0];
    assign w_we    = i_cmd.ld_shift | i_cmd.ld_put;
    assign w_wang  = i_cmd.ld_shift ? w_rang : r_ang;
    assign w_wval  = i_cmd.ld_shift ? w_rval : r_val;

    atli_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_angle_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wang),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rang)
    );

    atli_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wval),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rval)
    );

    // One restoring step: the remainder always stays below the span.
    assign w_trial = {r_rem, 1'b0};

    // v0 + (v1 - v0) * f, rounded half up, equals the two-term blend exactly.
    assign w_diff = $signed({1'b0, r_v1}) - $signed({1'b0, r_v0});
    assign w_frac = $signed({1'b0, r_quo});
    assign w_sum  = $signed({3'b000, r_v0, 16'h0000}) + $signed({r_prod[33], r_prod})
                  + $signed(35'd32768);
    assign w_interp = (w_sum[34:16] > {3'b000, VALUE_ONE}) ? VALUE_ONE : w_sum[31:16];

    always_comb begin
        case (i_cmd.fin_sel)
            RS_RDVAL:  w_res = w_rval;
            RS_V0:     w_res = r_v0;
            RS_V1:     w_res = r_v1;
            RS_INTERP: w_res = w_interp;
            default:   w_res = 16'h0000;
        endcase
    end

    always_comb begin
        o_stat.full      = (r_count == CW'(DEPTH));
        o_stat.k_zero    = (r_k == '0);
        o_stat.ld_gt     = (w_rang > r_ang);
        o_stat.q_end     = (r_i >= r_count);
        o_stat.q_hit     = (w_rang >= r_q);
        o_stat.i_zero    = (r_i == '0);
        o_stat.q_eq      = (r_q == r_a1);
        o_stat.span_zero = (r_a1 <= r_a0);
        o_stat.div_last  = (r_dcnt == DIV_LAST_STEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MAX_ANGLE_RESET;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_count <= '0;
            end else if (i_cmd.ld_put) begin
                r_count <= r_count + CW'(1);
            end
            r_done <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_ang <= i_entry_angle;
            r_val <= (i_entry_value > VALUE_ONE) ? VALUE_ONE : i_entry_value;
            r_q   <= (i_query_angle > r_max) ? r_max : i_query_angle;
        end
        if (i_cmd.ld_init) begin
            r_k <= r_count;
        end else if (i_cmd.ld_shift) begin
            r_k <= w_k_dec;
        end
        if (i_cmd.q_init) begin
            r_i <= '0;
        end else if (i_cmd.q_next) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.q_next) begin
            r_a0 <= w_rang;
            r_v0 <= w_rval;
        end
        if (i_cmd.cap_hi) begin
            r_a1 <= w_rang;
            r_v1 <= w_rval;
        end
        if (i_cmd.div_init) begin
            r_rem  <= r_q - r_a0;
            r_span <= r_a1 - r_a0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, r_span}) begin
                r_rem <= 16'(w_trial - {1'b0, r_span});
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= w_trial[15:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 4'd1;
        end
        if (i_cmd.mul) begin
            r_prod <= w_diff * w_frac;
        end
        if (i_cmd.fin) begin
            r_result <= w_res;
            r_status <= i_cmd.fin_st;
        end
    end

    assign o_done         = r_done;
    assign o_result_value = r_result;
    assign o_status       = r_status;

endmodule
